// ----- rtl/core/bfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// bfsp_pkg
// Shared types, constants and helpers for the shortest path engine.
// ----------------------------------------------------------------------------
package bfsp_pkg;

	localparam int MAX_NODES   = 64;
	localparam int MAX_EDGES   = 256;
	localparam int WEIGHT_BITS = 16;

	localparam int MODE_W   = 2;
	localparam int FIELD_NW = 6;
	localparam int IN_WT_W  = 16;
	localparam int CFG_W    = 7;
	localparam int DIST_W   = 32;

	localparam int NODE_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	localparam logic signed [DIST_W-1:0] INT_MAX = {1'b0, {(DIST_W-1){1'b1}}};
	localparam logic signed [DIST_W-1:0] INT_MIN = {1'b1, {(DIST_W-1){1'b0}}};

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD   = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_EDGE_RD,
		ST_EDGE_DEC,
		ST_SUM,
		ST_UPD,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT,
		ST_NEG
	} state_t;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic [FIELD_NW-1:0]    head;
		logic [FIELD_NW-1:0]    tail;
	} edge_t;

	typedef struct packed {
		logic               we;
		logic [EDGE_AW-1:0] waddr;
		edge_t              wdata;
		logic               re;
		logic [EDGE_AW-1:0] raddr;
	} edge_req_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic [DIST_W-1:0] wdata;
		logic              re;
		logic [NODE_W-1:0] raddr_a;
		logic [NODE_W-1:0] raddr_b;
	} dist_req_t;

	function automatic logic signed [DIST_W-1:0] sat_add(
		input logic signed [DIST_W-1:0] a,
		input logic signed [DIST_W-1:0] b
	);
		logic signed [DIST_W:0] s;
		s = {a[DIST_W-1], a} + {b[DIST_W-1], b};
		if (s[DIST_W] != s[DIST_W-1]) begin
			return s[DIST_W] ? INT_MIN : INT_MAX;
		end
		return s[DIST_W-1:0];
	endfunction

endpackage

// ----- rtl/core/bellman_ford_shortest_paths.sv -----
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths
// Single-source shortest paths over a loaded store of weighted directed edges.
// ----------------------------------------------------------------------------
// Add and clear requests complete as they are accepted; one can follow every
// cycle while no run is in progress. A run walks the stored edges in up to
// node_count relaxation passes and a check pass, stopping after a pass with
// no update; each edge is a read-modify-write of the distance store. Results
// leave one at a time, held while m_tready is low. Reset empties the edge
// store and sets node_count to 64; memories are not cleared.
module bellman_ford_shortest_paths (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bfsp_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,  // from_node, to_node, edge_weight, zero pad
	input  logic [1:0]                 s_tuser,  // mode
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [39:0]                m_tdata,  // vertex, distance, reachable, zero pad
	output logic [0:0]                 m_tuser,  // negative_cycle
	output logic                       m_tlast
);
	import bfsp_pkg::*;

	edge_req_t         edge_req;
	edge_t             edge_rdata;
	dist_req_t         dist_req;
	logic [DIST_W-1:0] dist_rdata_a;
	logic [DIST_W-1:0] dist_rdata_b;

	logic [FIELD_NW-1:0] out_vertex;
	logic [DIST_W-1:0]   out_distance;
	logic                out_reachable;
	logic                out_neg;

	logic unused_pad;
	assign unused_pad = ^s_tdata[31:28];

	bfsp_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_mode      (s_tuser),
		.in_from      (s_tdata[5:0]),
		.in_to        (s_tdata[11:6]),
		.in_weight    (s_tdata[27:12]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_vertex   (out_vertex),
		.out_distance (out_distance),
		.out_reachable(out_reachable),
		.out_neg      (out_neg),
		.out_last     (m_tlast),
		.edge_req     (edge_req),
		.edge_rdata   (edge_rdata),
		.dist_req     (dist_req),
		.dist_rdata_a (dist_rdata_a),
		.dist_rdata_b (dist_rdata_b)
	);

	bfsp_edge_ram u_edge_ram (
		.clk  (clk),
		.req  (edge_req),
		.rdata(edge_rdata)
	);

	bfsp_dist_ram u_dist_ram (
		.clk    (clk),
		.req    (dist_req),
		.rdata_a(dist_rdata_a),
		.rdata_b(dist_rdata_b)
	);

	assign m_tdata = {1'b0, out_reachable, out_distance, out_vertex};
	assign m_tuser = out_neg;

endmodule

// ----- rtl/core/bfsp_edge_ram.sv -----
// ----------------------------------------------------------------------------
// bfsp_edge_ram
// Edge store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfsp_edge_ram (
	input  logic              clk,
	input  bfsp_pkg::edge_req_t req,
	output bfsp_pkg::edge_t   rdata
);
	import bfsp_pkg::*;

	edge_t mem [MAX_EDGES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ----- rtl/core/bfsp_dist_ram.sv -----
// ----------------------------------------------------------------------------
// bfsp_dist_ram
// Distance store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module bfsp_dist_ram (
	input  logic                        clk,
	input  bfsp_pkg::dist_req_t         req,
	output logic [bfsp_pkg::DIST_W-1:0] rdata_a,
	output logic [bfsp_pkg::DIST_W-1:0] rdata_b
);
	import bfsp_pkg::*;

	logic [DIST_W-1:0] mem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_a <= mem[req.raddr_a];
			rdata_b <= mem[req.raddr_b];
		end
	end

endmodule

// ----- rtl/core/bfsp_ctrl.sv -----
// ----------------------------------------------------------------------------
// bfsp_ctrl
// Sequencer: loads edges, runs relaxation passes over the edge store with
// read-modify-write of the distance store, and returns the results.
// ----------------------------------------------------------------------------
module bfsp_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bfsp_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bfsp_pkg::MODE_W-1:0]   in_mode,
	input  logic [bfsp_pkg::FIELD_NW-1:0] in_from,
	input  logic [bfsp_pkg::FIELD_NW-1:0] in_to,
	input  logic [bfsp_pkg::IN_WT_W-1:0]  in_weight,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bfsp_pkg::FIELD_NW-1:0] out_vertex,
	output logic [bfsp_pkg::DIST_W-1:0]   out_distance,
	output logic                          out_reachable,
	output logic                          out_neg,
	output logic                          out_last,
	output bfsp_pkg::edge_req_t           edge_req,
	input  bfsp_pkg::edge_t               edge_rdata,
	output bfsp_pkg::dist_req_t           dist_req,
	input  logic [bfsp_pkg::DIST_W-1:0]   dist_rdata_a,
	input  logic [bfsp_pkg::DIST_W-1:0]   dist_rdata_b
);
	import bfsp_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0]     n_q;
	logic [EDGE_AW:0]     edge_total_q;
	logic [MAX_NODES-1:0] reach_q;
	logic [CFG_W-1:0]     pass_q;
	logic                 changed_q;
	logic [EDGE_AW-1:0]   eidx_q;
	logic [NODE_W-1:0]    out_idx_q;
	logic                 out_valid_q;

	logic [FIELD_NW-1:0]     src_q;
	logic [FIELD_NW-1:0]     head_q;
	logic [WEIGHT_BITS-1:0]  weight_q;
	logic                    skip_q;
	logic signed [DIST_W-1:0] sum_q;

	logic [CFG_W-1:0] cfg_eff;
	logic             accept;
	logic             check_pass;
	logic             last_edge;
	logic             relax;
	logic             src_ok;
	logic             out_is_last;
	logic             dec_skip;
	logic [EDGE_AW:0] eidx_inc;

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_eff = CFG_W'(1);
		end else if (cfg_wdata > CFG_W'(MAX_NODES)) begin
			cfg_eff = CFG_W'(MAX_NODES);
		end else begin
			cfg_eff = cfg_wdata;
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign check_pass  = (pass_q == n_q);
	assign eidx_inc    = {1'b0, eidx_q} + (EDGE_AW+1)'(1);
	assign last_edge   = (eidx_inc == edge_total_q);
	assign src_ok      = (CFG_W'(src_q) < n_q);
	assign out_is_last = ((CFG_W'(out_idx_q) + CFG_W'(1)) == n_q);
	assign relax       = !skip_q && (!reach_q[head_q[NODE_W-1:0]] ||
		(sum_q < $signed(dist_rdata_b)));
	assign dec_skip    = (CFG_W'(edge_rdata.tail) >= n_q) || (CFG_W'(edge_rdata.head) >= n_q) ||
		!reach_q[edge_rdata.tail[NODE_W-1:0]];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_mode == MODE_RUN)) begin
					state_d = ST_INIT;
				end
			end
			ST_INIT: begin
				state_d = (edge_total_q == '0) ? ST_OUT_RD : ST_EDGE_RD;
			end
			ST_EDGE_RD:  state_d = ST_EDGE_DEC;
			ST_EDGE_DEC: state_d = ST_SUM;
			ST_SUM:      state_d = ST_UPD;
			ST_UPD: begin
				if (relax && check_pass) begin
					state_d = ST_NEG;
				end else if (last_edge && (check_pass || !(changed_q || relax))) begin
					state_d = ST_OUT_RD;
				end else begin
					state_d = ST_EDGE_DEC;
				end
			end
			ST_OUT_RD: state_d = ST_OUT_LD;
			ST_OUT_LD: state_d = ST_OUT_WAIT;
			ST_NEG:    state_d = ST_OUT_WAIT;
			ST_OUT_WAIT: begin
				if (out_ready) begin
					state_d = out_last ? ST_IDLE : ST_OUT_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		edge_req       = '0;
		dist_req       = '0;
		edge_req.waddr = edge_total_q[EDGE_AW-1:0];
		edge_req.wdata = '{weight: WEIGHT_BITS'(in_weight), head: in_to, tail: in_from};
		edge_req.we    = accept && (in_mode == MODE_ADD) &&
			(edge_total_q < (EDGE_AW+1)'(MAX_EDGES));
		unique case (state_q)
			ST_INIT: begin
				dist_req.we    = src_ok;
				dist_req.waddr = src_q[NODE_W-1:0];
				dist_req.wdata = '0;
			end
			ST_EDGE_RD: begin
				edge_req.re    = 1'b1;
				edge_req.raddr = eidx_q;
			end
			ST_EDGE_DEC: begin
				dist_req.re      = 1'b1;
				dist_req.raddr_a = edge_rdata.tail[NODE_W-1:0];
				dist_req.raddr_b = edge_rdata.head[NODE_W-1:0];
			end
			ST_UPD: begin
				dist_req.we    = relax && !check_pass;
				dist_req.waddr = head_q[NODE_W-1:0];
				dist_req.wdata = sum_q;
				edge_req.re    = 1'b1;
				edge_req.raddr = last_edge ? '0 : eidx_inc[EDGE_AW-1:0];
			end
			ST_OUT_RD: begin
				dist_req.re      = 1'b1;
				dist_req.raddr_a = out_idx_q;
				dist_req.raddr_b = out_idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			n_q          <= CFG_W'(MAX_NODES);
			edge_total_q <= '0;
			reach_q      <= '0;
			pass_q       <= '0;
			changed_q    <= 1'b0;
			eidx_q       <= '0;
			out_idx_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				n_q <= cfg_eff;
			end
			if (accept) begin
				unique case (in_mode)
					MODE_ADD: begin
						if (edge_req.we) begin
							edge_total_q <= edge_total_q + (EDGE_AW+1)'(1);
						end
					end
					MODE_CLEAR: edge_total_q <= '0;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_INIT: begin
					reach_q   <= src_ok ? (MAX_NODES'(1) << src_q[NODE_W-1:0]) : '0;
					pass_q    <= '0;
					changed_q <= 1'b0;
					eidx_q    <= '0;
					out_idx_q <= '0;
				end
				ST_UPD: begin
					if (relax && !check_pass) begin
						reach_q[head_q[NODE_W-1:0]] <= 1'b1;
					end
					if (last_edge) begin
						eidx_q    <= '0;
						pass_q    <= pass_q + CFG_W'(1);
						changed_q <= 1'b0;
					end else begin
						eidx_q <= eidx_inc[EDGE_AW-1:0];
						if (relax && !check_pass) begin
							changed_q <= 1'b1;
						end
					end
				end
				ST_OUT_LD, ST_NEG: out_valid_q <= 1'b1;
				ST_OUT_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						out_idx_q   <= out_idx_q + NODE_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					src_q <= in_from;
				end
			end
			ST_EDGE_DEC: begin
				head_q   <= edge_rdata.head;
				weight_q <= edge_rdata.weight;
				skip_q   <= dec_skip;
			end
			ST_SUM: begin
				sum_q <= sat_add($signed(dist_rdata_a), DIST_W'($signed(weight_q)));
			end
			ST_OUT_LD: begin
				out_vertex    <= FIELD_NW'(out_idx_q);
				out_reachable <= reach_q[out_idx_q];
				out_distance  <= reach_q[out_idx_q] ? dist_rdata_a : '0;
				out_neg       <= 1'b0;
				out_last      <= out_is_last;
			end
			ST_NEG: begin
				out_vertex    <= '0;
				out_reachable <= 1'b0;
				out_distance  <= '0;
				out_neg       <= 1'b1;
				out_last      <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/bfsp_checker.sv -----
// ----------------------------------------------------------------------------
// bfsp_checker
// Port-level checks on the result stream of the shortest path engine.
// ----------------------------------------------------------------------------
module bfsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("request taken while a result is pending");

	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
		else $error("malformed negative cycle result");

	a_unreach: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[38] |-> (m_tdata[37:6] == '0))
		else $error("unreachable vertex with nonzero distance");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
		else $error("block not idle after final result");

endmodule

bind bellman_ford_shortest_paths bfsp_checker u_bfsp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
